>>> design/swrd_pkg.sv
// Shared constants, register codes and control structs of the sliding window range detector.
`timescale 1ns / 1ps

package swrd_pkg;

   localparam int MAX_WINDOW_DEFAULT  = 256;
   localparam int SAMPLE_BITS_DEFAULT = 16;

   localparam int WINDOW_LEN_BITS = 9;
   localparam int THRESHOLD_BITS  = 16;
   localparam int POSITION_BITS   = 32;
   localparam int CSR_DATA_BITS   = 16;
   localparam int CSR_INDEX_BITS  = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_WINDOW_LEN      = 1'b0,
      CSR_QUIET_THRESHOLD = 1'b1
   } csr_index_type;

   // Per-cycle command shared by every cell of one queue.
   typedef struct packed {
      logic push;   // insert a new sample, cutting dominated entries at the tail
      logic drop;   // the head entry has expired and leaves during this push
      logic shift;  // move every entry one cell toward the head, no insert
   } cell_ctrl_type;

   // Top level to queue.
   typedef struct packed {
      logic push;     // a transaction is accepted this cycle
      logic pending;  // a transaction is waiting at the input
   } queue_req_type;

   // Queue to top level.
   typedef struct packed {
      logic shift_needed;  // more than one entry has expired; the head must be cleared first
   } queue_status_type;

endpackage

>>> design/sliding_window_range_detector_top.sv
// A result transaction is presented in the cycle after its sample is accepted.
// Throughput: one sample per cycle unless rsp_stall or an expired-entry backlog holds it.
// After window_len is shortened, the next sample is stalled while the chains clear the
// expired entries beyond the first from their heads, one cell per cycle while it waits.
// Reset clears fill counts, sample count and output valid flag; there is no clearing pass.
`timescale 1ns / 1ps

module sliding_window_range_detector_top
   import swrd_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   // Configuration write port.
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   // Sample input channel.
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [SAMPLE_BITS-1:0]    req_sample,
   // Result channel.
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [POSITION_BITS-1:0]  rsp_window_start,
   output logic [SAMPLE_BITS-1:0]    rsp_window_max,
   output logic [SAMPLE_BITS-1:0]    rsp_window_min,
   output logic                      rsp_is_quiet
);

   // Width that holds every window length from one up to MAX_WINDOW.
   localparam int LEN_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS = (SAMPLE_BITS > THRESHOLD_BITS) ? SAMPLE_BITS : THRESHOLD_BITS;

   // Configuration. The window length is clamped to 1..MAX_WINDOW as it is written,
   // so the datapath only ever sees a legal length.
   logic [LEN_BITS-1:0]        len_ff;
   logic [LEN_BITS-1:0]        len_in;
   logic [THRESHOLD_BITS-1:0]  threshold_ff;
   logic [THRESHOLD_BITS-1:0]  threshold_in;
   logic [WINDOW_LEN_BITS-1:0] wdata_len;

   // Sample counting and result formation.
   logic [POSITION_BITS-1:0]   sample_count_ff;
   logic [POSITION_BITS-1:0]   sample_count_in;
   logic [POSITION_BITS-1:0]   len_wide;
   logic                       result_valid;
   logic [SAMPLE_BITS-1:0]     max_front;
   logic [SAMPLE_BITS-1:0]     min_front_inv;
   logic [SAMPLE_BITS-1:0]     window_max;
   logic [SAMPLE_BITS-1:0]     window_min;
   logic [CMP_BITS-1:0]        range;
   logic                       quiet;

   // Handshake.
   logic                       out_free;
   logic                       accept;
   queue_req_type              queue_req;
   queue_status_type           max_status;
   queue_status_type           min_status;

   // Output register.
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic [POSITION_BITS-1:0]   window_start_ff;
   logic [SAMPLE_BITS-1:0]     window_max_ff;
   logic [SAMPLE_BITS-1:0]     window_min_ff;
   logic                       is_quiet_ff;

   //------------------------------------------------------------------------
   // Configuration registers.
   //------------------------------------------------------------------------
   assign wdata_len = csr_wdata[WINDOW_LEN_BITS-1:0];

   always_comb begin
      len_in       = len_ff;
      threshold_in = threshold_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_LEN: begin
               priority if (wdata_len == '0) begin
                  len_in = LEN_BITS'(1);
               end else if (32'(wdata_len) > 32'(MAX_WINDOW)) begin
                  len_in = LEN_BITS'(MAX_WINDOW);
               end else begin
                  len_in = LEN_BITS'(wdata_len);
               end
            end
            CSR_QUIET_THRESHOLD: begin
               threshold_in = csr_wdata[THRESHOLD_BITS-1:0];
            end
            default: begin
               len_in       = len_ff;
               threshold_in = threshold_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= LEN_BITS'(1);
         threshold_ff <= '0;
      end else begin
         len_ff       <= len_in;
         threshold_ff <= threshold_in;
      end
   end

   //------------------------------------------------------------------------
   // Flow control. A sample transaction is taken when the output register
   // can accept its result and neither queue has a backlog of expired
   // entries to clear. The output register lets the next sample enter in
   // the same cycle that the previous result leaves.
   //------------------------------------------------------------------------
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = max_status.shift_needed | min_status.shift_needed | ~out_free;
   assign accept    = req_valid & ~req_stall;

   assign queue_req.push    = accept;
   assign queue_req.pending = req_valid;

   //------------------------------------------------------------------------
   // Two cell chains. Both keep a non-increasing queue; the minimum queue
   // runs on inverted samples, so its head inverted back is the window
   // minimum. Each chain pops expired entries at its head and dominated
   // entries at its tail in the same cycle as the insert.
   //------------------------------------------------------------------------
   swrd_queue #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .LEN_BITS   (LEN_BITS)
   ) u_max_queue (
      .clock (clock),
      .reset (reset),
      .req   (queue_req),
      .sample(req_sample),
      .len   (len_ff),
      .status(max_status),
      .front (max_front)
   );

   swrd_queue #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS),
      .LEN_BITS   (LEN_BITS)
   ) u_min_queue (
      .clock (clock),
      .reset (reset),
      .req   (queue_req),
      .sample(~req_sample),
      .len   (len_ff),
      .status(min_status),
      .front (min_front_inv)
   );

   assign window_max = max_front;
   assign window_min = ~min_front_inv;

   //------------------------------------------------------------------------
   // Sample count and result. The count saturates at its all-ones value;
   // the queues age their entries on their own, so saturation only
   // freezes the reported window start.
   //------------------------------------------------------------------------
   assign sample_count_in = (sample_count_ff == '1) ? sample_count_ff
                                                    : sample_count_ff + POSITION_BITS'(1);
   assign len_wide        = POSITION_BITS'(len_ff);
   assign result_valid    = sample_count_in >= len_wide;

   assign range = CMP_BITS'(window_max) - CMP_BITS'(window_min);
   assign quiet = (window_max >= window_min) && (range <= CMP_BITS'(threshold_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_count_ff <= '0;
      end else if (accept) begin
         sample_count_ff <= sample_count_in;
      end
   end

   //------------------------------------------------------------------------
   // Output register. A result transaction holds until it is taken.
   //------------------------------------------------------------------------
   always_comb begin
      priority if (accept) begin
         rsp_valid_in = result_valid;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         window_start_ff <= sample_count_in - len_wide + POSITION_BITS'(1);
         window_max_ff   <= window_max;
         window_min_ff   <= window_min;
         is_quiet_ff     <= quiet;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_window_start = window_start_ff;
   assign rsp_window_max   = window_max_ff;
   assign rsp_window_min   = window_min_ff;
   assign rsp_is_quiet     = is_quiet_ff;

endmodule

>>> design/swrd_cell.sv
// One cell of the monotonic queue chain: holds one sample and its age.
`timescale 1ns / 1ps

module swrd_cell
   import swrd_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LEN_BITS    = $clog2(MAX_WINDOW_DEFAULT + 1)
) (
   input  logic                   clock,
   input  cell_ctrl_type          ctrl,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [LEN_BITS-1:0]    len,
   input  logic                   valid,
   input  logic                   prev_keep,
   input  logic                   right_keep,
   input  logic [SAMPLE_BITS-1:0] right_value,
   input  logic [LEN_BITS-1:0]    right_age,
   output logic                   keep,
   output logic [SAMPLE_BITS-1:0] value,
   output logic [LEN_BITS-1:0]    age,
   output logic                   aged,
   output logic                   append,
   output logic [SAMPLE_BITS-1:0] next_value
);

   logic [SAMPLE_BITS-1:0] value_ff;
   logic [LEN_BITS-1:0]    age_ff;
   logic                   src_keep;
   logic [SAMPLE_BITS-1:0] src_value;
   logic [LEN_BITS-1:0]    src_age;

   // An entry survives a push unless the new sample is at least as large.
   assign keep  = valid & (sample < value_ff);
   assign aged  = valid & (age_ff >= len);
   assign value = value_ff;
   assign age   = age_ff;

   // When the head expires, every cell looks at its right neighbor's entry.
   assign src_keep  = ctrl.drop ? right_keep  : keep;
   assign src_value = ctrl.drop ? right_value : value_ff;
   assign src_age   = ctrl.drop ? right_age   : age_ff;

   assign append     = ctrl.push & ~src_keep & prev_keep;
   assign next_value = src_keep ? src_value : sample;

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         value_ff <= right_value;
         age_ff   <= right_age;
      end else if (ctrl.push && (src_keep || prev_keep)) begin
         value_ff <= next_value;
         age_ff   <= src_keep ? (src_age + LEN_BITS'(1)) : LEN_BITS'(1);
      end
   end

endmodule

>>> design/swrd_queue.sv
// Non-increasing monotonic queue built as a chain of cells with the head in cell zero.
`timescale 1ns / 1ps

module swrd_queue
   import swrd_pkg::*;
#(
   parameter int MAX_WINDOW  = MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT,
   parameter int LEN_BITS    = $clog2(MAX_WINDOW + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  queue_req_type          req,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  logic [LEN_BITS-1:0]    len,
   output queue_status_type       status,
   output logic [SAMPLE_BITS-1:0] front
);

   logic [LEN_BITS-1:0]    count_ff;
   logic [LEN_BITS-1:0]    count_in;
   logic [LEN_BITS-1:0]    append_index;
   cell_ctrl_type          ctrl;
   logic [MAX_WINDOW-1:0]  valid;
   logic [MAX_WINDOW-1:0]  keep;
   logic [MAX_WINDOW-1:0]  aged;
   logic [MAX_WINDOW-1:0]  append;
   logic [MAX_WINDOW-1:0]  prev_keep;
   logic [SAMPLE_BITS-1:0] value      [MAX_WINDOW];
   logic [LEN_BITS-1:0]    age        [MAX_WINDOW];
   logic [SAMPLE_BITS-1:0] next_value [MAX_WINDOW];

   // Only the head can expire in steady state; a second expired entry
   // means a shortened window; the head clears one per cycle while req.pending.
   assign ctrl.push  = req.push;
   assign ctrl.drop  = aged[0];
   assign ctrl.shift = req.pending & aged[1];

   assign status.shift_needed = aged[1];
   assign front               = next_value[0];

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      logic                   right_keep;
      logic [SAMPLE_BITS-1:0] right_value;
      logic [LEN_BITS-1:0]    right_age;

      assign valid[i] = LEN_BITS'(i) < count_ff;

      if (i == 0) begin : g_head
         assign prev_keep[i] = 1'b1;
      end else begin : g_body
         assign prev_keep[i] = ctrl.drop ? keep[i] : keep[i-1];
      end

      if (i == MAX_WINDOW - 1) begin : g_tail
         assign right_keep  = 1'b0;
         assign right_value = '0;
         assign right_age   = '0;
      end else begin : g_link
         assign right_keep  = keep[i+1];
         assign right_value = value[i+1];
         assign right_age   = age[i+1];
      end

      swrd_cell #(
         .SAMPLE_BITS(SAMPLE_BITS),
         .LEN_BITS   (LEN_BITS)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .sample     (sample),
         .len        (len),
         .valid      (valid[i]),
         .prev_keep  (prev_keep[i]),
         .right_keep (right_keep),
         .right_value(right_value),
         .right_age  (right_age),
         .keep       (keep[i]),
         .value      (value[i]),
         .age        (age[i]),
         .aged       (aged[i]),
         .append     (append[i]),
         .next_value (next_value[i])
      );
   end

   // Exactly one cell takes the new sample; its index sets the new fill count.
   always_comb begin
      append_index = '0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
         if (append[i]) begin
            append_index = append_index | LEN_BITS'(i);
         end
      end
   end

   always_comb begin
      priority if (ctrl.push) begin
         count_in = append_index + LEN_BITS'(1);
      end else if (ctrl.shift) begin
         count_in = count_ff - LEN_BITS'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

>>> dv/tb_sliding_window_range_detector_top.sv
// Self-checking testbench of the sliding window range detector with a built-in window predictor.
`timescale 1ns / 1ps

module tb_sliding_window_range_detector_top;
   import swrd_pkg::*;

   localparam int SW          = SAMPLE_BITS_DEFAULT;
   localparam int MAX_W       = MAX_WINDOW_DEFAULT;
   localparam int STUCK_LIMIT = 4000;
   localparam int DRAIN_WAIT  = 8;

   // One held queue entry: the sample value and the position at which it arrived.
   typedef struct packed {
      logic [SW-1:0]            value;
      logic [POSITION_BITS-1:0] pos;
   } chain_entry_type;

   // One expected result transaction.
   typedef struct packed {
      logic [POSITION_BITS-1:0] start;
      logic [SW-1:0]            wmax;
      logic [SW-1:0]            wmin;
      logic                     quiet;
   } window_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     csr_wen   = 1'b0;
   csr_index_type            csr_index = CSR_WINDOW_LEN;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   logic                     req_valid  = 1'b0;
   logic                     req_stall;
   logic [SW-1:0]            req_sample = '0;

   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [POSITION_BITS-1:0] rsp_window_start;
   logic [SW-1:0]            rsp_window_max;
   logic [SW-1:0]            rsp_window_min;
   logic                     rsp_is_quiet;

   // Stimulus and scoreboard state.
   logic [SW-1:0]     pending_samples[$];
   window_result_type expected_windows[$];
   logic              in_taken     = 1'b0;
   bit                calm         = 1'b0;
   int                send_gap     = 0;
   int                stall_left   = 0;
   int                stuck_cycles = 0;
   int                mismatch_count = 0;

   // Predictor state: index 0 is the maximum chain, index 1 the minimum chain.
   chain_entry_type            window_chain[2][$];
   logic [WINDOW_LEN_BITS-1:0] cfg_len;
   logic [THRESHOLD_BITS-1:0]  cfg_thr;
   logic [POSITION_BITS-1:0]   pos_ctr;
   logic [POSITION_BITS-1:0]   seen_count;

   sliding_window_range_detector_top i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wen          (csr_wen),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_window_start (rsp_window_start),
      .rsp_window_max   (rsp_window_max),
      .rsp_window_min   (rsp_window_min),
      .rsp_is_quiet     (rsp_is_quiet)
   );

   // 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch: %s got %0d expected %0d at %0t ns", what, got, want, $time);
   endtask

   // Advances the window predictor by one accepted sample and queues the result it causes,
   // if any. Zero and oversized window lengths are clamped to the legal range first.
   task automatic advance_window(input logic [SW-1:0] s);
      logic [POSITION_BITS-1:0] win;
      window_result_type        r;
      chain_entry_type          e;
      bit                       dominated;
      win = (cfg_len == 0) ? 1 : (cfg_len > MAX_W) ? MAX_W : cfg_len;
      for (int k = 0; k < 2; k++) begin
         // Entries that have slid out of the window leave at the head.
         while (window_chain[k].size() > 0 && (pos_ctr - window_chain[k][0].pos) >= win)
            window_chain[k].delete(0);
         // Entries at the tail that the new sample dominates (ties included) are cut.
         while (window_chain[k].size() > 0) begin
            if (k == 0)
               dominated = s >= window_chain[k][window_chain[k].size()-1].value;
            else
               dominated = s <= window_chain[k][window_chain[k].size()-1].value;
            if (!dominated) break;
            window_chain[k].delete(window_chain[k].size()-1);
         end
         if (window_chain[k].size() >= MAX_W)
            window_chain[k].delete(0);
         e.value = s;
         e.pos   = pos_ctr;
         window_chain[k].insert(window_chain[k].size(), e);
      end
      pos_ctr = pos_ctr + 1;
      if (seen_count != '1) seen_count = seen_count + 1;
      if (seen_count >= win) begin
         r.start = seen_count - win + 1;
         r.wmax  = window_chain[0][0].value;
         r.wmin  = window_chain[1][0].value;
         r.quiet = (r.wmax >= r.wmin) && ((r.wmax - r.wmin) <= cfg_thr);
         expected_windows.insert(expected_windows.size(), r);
      end
   endtask

   // Monitor: at every rising edge it mirrors register writes, feeds accepted samples
   // into the predictor and checks accepted results against the oldest expectation.
   always @(posedge clock) begin
      window_result_type w;
      bit                moved;
      in_taken <= req_valid && !req_stall;
      moved = 1'b0;
      if (reset) begin
         window_chain[0].delete();
         window_chain[1].delete();
         cfg_len    = WINDOW_LEN_BITS'(1);
         cfg_thr    = '0;
         pos_ctr    = '0;
         seen_count = '0;
         stuck_cycles = 0;
      end else begin
         if (csr_wen) begin
            if (csr_index == CSR_WINDOW_LEN)
               cfg_len = csr_wdata[WINDOW_LEN_BITS-1:0];
            else
               cfg_thr = csr_wdata[THRESHOLD_BITS-1:0];
         end
         if (req_valid && !req_stall) begin
            advance_window(req_sample);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_windows.size() == 0) begin
               report_mismatch("result with nothing expected, window_start",
                               rsp_window_start, 32'd0);
            end else begin
               w = expected_windows[0];
               expected_windows.delete(0);
               if (rsp_window_start !== w.start)
                  report_mismatch("window_start", rsp_window_start, w.start);
               if (rsp_window_max !== w.wmax)
                  report_mismatch("window_max", 32'(rsp_window_max), 32'(w.wmax));
               if (rsp_window_min !== w.wmin)
                  report_mismatch("window_min", 32'(rsp_window_min), 32'(w.wmin));
               if (rsp_is_quiet !== w.quiet)
                  report_mismatch("is_quiet", 32'(rsp_is_quiet), 32'(w.quiet));
            end
         end
         // The watchdog only counts while work is outstanding and nothing moves.
         if (moved)
            stuck_cycles = 0;
         else if (pending_samples.size() > 0 || req_valid || expected_windows.size() > 0)
            stuck_cycles++;
      end
   end

   // Watchdog: a run that stops making progress ends as a failure.
   always @(posedge clock) begin
      if (!reset && stuck_cycles >= STUCK_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // Sample driver. A new transaction is presented at the falling edge once the previous
   // one was accepted; idle gaps are inserted at random until the closing phase. A
   // presented sample is held unchanged while the design stalls.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || in_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_valid  <= 1'b1;
            req_sample <= pending_samples[0];
            pending_samples.delete(0);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result receiver: stalls in random bursts, never in the closing phase.
   always @(negedge clock) begin
      if (reset || calm) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 5);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Writes one register; only called while the design is idle.
   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_BITS-1:0] data);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   // Waits until every queued sample is accepted and every expected result has arrived,
   // then waits out a settling period so a sample that caused no result is fully absorbed.
   // Checks happen just after the falling edge so the driver has settled.
   task automatic drain_pipeline();
      do begin
         @(negedge clock);
         #1;
      end while (pending_samples.size() > 0 || req_valid || expected_windows.size() > 0);
      repeat (DRAIN_WAIT) @(negedge clock);
      #1;
   endtask

   // Queues n samples built from runs of different shapes: uniform noise, a narrow band
   // (so quiet windows occur), rising and falling ramps that stress the chain tails,
   // constant runs for ties, and runs that jump between the two extremes.
   task automatic queue_samples(input int n);
      int            run_left;
      int            shape;
      int            step;
      logic [SW-1:0] base;
      logic [SW-1:0] s;
      run_left = 0;
      shape    = 0;
      step     = 1;
      base     = '0;
      for (int i = 0; i < n; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(4, 40);
            shape    = $urandom_range(0, 5);
            base     = SW'($urandom);
            step     = $urandom_range(1, 300);
         end
         run_left--;
         case (shape)
            0: s = SW'($urandom);
            1: s = SW'(base + $urandom_range(0, 15));
            2: begin
               base = SW'(base + step);
               s    = base;
            end
            3: begin
               base = SW'(base - step);
               s    = base;
            end
            4: s = base;
            default: s = $urandom_range(0, 1) ? '1 : '0;
         endcase
         pending_samples.insert(pending_samples.size(), s);
      end
   endtask

   initial begin
      logic [CSR_DATA_BITS-1:0] len_word;
      logic [CSR_DATA_BITS-1:0] thr_word;
      int                       n_items;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed part. Reset values first: a window of one, so every sample is its own
      // window and always quiet, including both sample extremes and a repeated value.
      pending_samples = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555, 16'h1234, 16'h1234};
      drain_pipeline();

      // A zero window length behaves like one; the widest threshold.
      write_csr(CSR_WINDOW_LEN, 16'h0000);
      write_csr(CSR_QUIET_THRESHOLD, 16'hFFFF);
      pending_samples = '{16'hFFFF, 16'h0000, 16'h0007};
      drain_pipeline();

      // Window of four: the stream continues, so the first samples of the run already give
      // results over windows that still hold older entries, equal samples replace queued ones,
      // and the range crosses a small threshold in both directions.
      write_csr(CSR_WINDOW_LEN, 16'h0004);
      write_csr(CSR_QUIET_THRESHOLD, 16'h0002);
      pending_samples = '{16'h0007, 16'h0007, 16'h0007, 16'h0007, 16'h0009,
                          16'h0005, 16'h0005, 16'h0000, 16'hFFFF};
      drain_pipeline();

      // Upper data bits of the window length register are not part of the length.
      write_csr(CSR_WINDOW_LEN, 16'hFE03);
      write_csr(CSR_QUIET_THRESHOLD, 16'h0000);
      pending_samples = '{16'h0003, 16'h0003, 16'h0003, 16'hFFFE};
      drain_pipeline();

      // Random phases. The window length changes between phases without a reset, so
      // lengthening and shortening mid-stream are both exercised; the early phases
      // cover the largest window, a length above the maximum and a zero length.
      for (int p = 0; p < 12; p++) begin
         case (p)
            0: len_word = CSR_DATA_BITS'(MAX_W);
            1: len_word = 16'hFFFF;
            2: len_word = 16'h0000;
            3: len_word = CSR_DATA_BITS'($urandom_range(MAX_W + 1, 511));
            default: begin
               len_word = CSR_DATA_BITS'($urandom_range(1, 16));
               len_word[CSR_DATA_BITS-1:WINDOW_LEN_BITS] =
                  (CSR_DATA_BITS - WINDOW_LEN_BITS)'($urandom);
            end
         endcase
         case ($urandom_range(0, 3))
            0: thr_word = 16'h0000;
            1: thr_word = 16'hFFFF;
            2: thr_word = CSR_DATA_BITS'($urandom_range(0, 40));
            default: thr_word = CSR_DATA_BITS'($urandom);
         endcase
         write_csr(CSR_WINDOW_LEN, len_word);
         write_csr(CSR_QUIET_THRESHOLD, thr_word);

         // Long windows need more samples before results appear.
         n_items = (len_word[WINDOW_LEN_BITS-1:0] >= MAX_W) ? 300 : 70;

         // The last phase runs without any idling on either side.
         if (p == 11) calm = 1'b1;

         if (p == 5) begin
            // Pause the sender mid-stream until every expected result has arrived.
            queue_samples(n_items / 2);
            drain_pipeline();
            queue_samples(n_items - n_items / 2);
         end else begin
            queue_samples(n_items);
         end
         drain_pipeline();
      end

      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
